>>> sv/pis_pkg.sv
// ----------------------------------------------------------------------------
// pis_pkg
// Shared types and constants of the PID unit with integral separation:
// register indexes, reset values, drive limits and stage payload structs.
// ----------------------------------------------------------------------------
package pis_pkg;

   // Configuration register indexes
   localparam logic [7:0] REG_SETPOINT   = 8'd0;
   localparam logic [7:0] REG_GAIN_P     = 8'd1;
   localparam logic [7:0] REG_GAIN_I     = 8'd2;
   localparam logic [7:0] REG_GAIN_D     = 8'd3;
   localparam logic [7:0] REG_SUM_HIGH   = 8'd4;
   localparam logic [7:0] REG_SUM_LOW    = 8'd5;
   localparam logic [7:0] REG_SEP_LIMIT  = 8'd6;
   localparam logic [7:0] REG_OUT_MAX    = 8'd7;

   // Register reset values
   localparam logic signed [15:0] SETPOINT_RST  = 16'sd0;
   localparam logic [31:0]        GAIN_P_RST    = 32'd24903680;
   localparam logic [31:0]        GAIN_I_RST    = 32'd62259;
   localparam logic [31:0]        GAIN_D_RST    = 32'd52429;
   localparam logic signed [31:0] SUM_HIGH_RST  = 32'sd160000;
   localparam logic signed [31:0] SUM_LOW_RST   = -32'sd160000;
   localparam logic [16:0]        SEP_LIMIT_RST = 17'd320;
   localparam logic [19:0]        OUT_MAX_RST   = 20'd19900;

   // Drive limits and error thresholds
   localparam logic [19:0]        DRIVE_FLOOR = 20'd8000;
   localparam logic [19:0]        DRIVE_MAX   = 20'hFFFFF;
   localparam logic [16:0]        BIG_ERROR   = 17'd80;
   localparam logic signed [31:0] SUM_MAX     = 32'sh7FFFFFFF;
   localparam logic signed [31:0] SUM_MIN     = 32'sh80000000;

   // Payload of the error stage
   typedef struct packed {
      logic signed [16:0] err;
      logic signed [17:0] diff;
      logic signed [31:0] sum;     // zero when the integral is off
      logic               active;
      logic               big;
   } pis_err_type;

   // Stage advance strobes for the drive path
   typedef struct packed {
      logic adv_mul;
      logic adv_out;
   } pis_ctrl_type;

endpackage

>>> sv/pis_drive_path.sv
// ----------------------------------------------------------------------------
// pis_drive_path
// Drive datapath: registered gain products, then the summed and shifted
// drive with floor, large-error override and saturation in the result register.
// ----------------------------------------------------------------------------
module pis_drive_path import pis_pkg::*; (
   input  logic         clock,
   input  pis_ctrl_type ctrl,
   input  pis_err_type  err_stage,
   input  logic [31:0]  gain_p,
   input  logic [31:0]  gain_i,
   input  logic [31:0]  gain_d,
   input  logic [19:0]  out_max,
   output logic [19:0]  drive,
   output logic         integral_active
);

   logic signed [49:0] prod_p_ff, prod_p_in;
   logic signed [64:0] prod_i_ff, prod_i_in;
   logic signed [50:0] prod_d_ff, prod_d_in;
   logic               active_ff;
   logic               big_ff;
   logic signed [65:0] total;
   logic signed [45:0] quot;
   logic [44:0]        floored;
   logic [20:0]        over_val;
   logic [19:0]        drive_ff, drive_in;
   logic               act_out_ff;

   // Form the three products with unsigned gains
   always_comb begin
      prod_p_in = $signed({1'b0, gain_p}) * err_stage.err;
      prod_i_in = $signed({1'b0, gain_i}) * err_stage.sum;
      prod_d_in = $signed({1'b0, gain_d}) * err_stage.diff;
   end

   always_ff @(posedge clock) begin
      if (ctrl.adv_mul) begin
         prod_p_ff <= prod_p_in;
         prod_i_ff <= prod_i_in;
         prod_d_ff <= prod_d_in;
         active_ff <= err_stage.active;
         big_ff    <= err_stage.big;
      end
   end

   // Sum exactly, floor-shift by 20, then floor, override and saturate
   always_comb begin
      total    = 66'(prod_p_ff) + 66'(prod_i_ff) + 66'(prod_d_ff);
      quot     = total[65:20];
      over_val = {1'b0, out_max} + 21'd1;
      if (quot <= $signed({26'd0, DRIVE_FLOOR})) begin
         floored = {25'd0, DRIVE_FLOOR};
      end else begin
         floored = quot[44:0];
      end
      if (floored >= {25'd0, out_max} && big_ff) begin
         drive_in = over_val[20] ? DRIVE_MAX : over_val[19:0];
      end else if (floored > {25'd0, DRIVE_MAX}) begin
         drive_in = DRIVE_MAX;
      end else begin
         drive_in = floored[19:0];
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.adv_out) begin
         drive_ff   <= drive_in;
         act_out_ff <= active_ff;
      end
   end

   assign drive           = drive_ff;
   assign integral_active = act_out_ff;

endmodule

>>> sv/pid_integral_separation_unit.sv
// ----------------------------------------------------------------------------
// pid_integral_separation_unit
// PID controller with integral separation and conditional integration.
//
//  channel | direction | handshake            | payload
//  req_    | in        | req_valid/req_stall  | req_measurement (Q12.4 signed)
//  rsp_    | out       | rsp_valid/rsp_stall  | rsp_drive, rsp_integral_active
//  csr_    | in        | csr_valid/csr_ready  | csr_index, csr_wdata
//
// One sample per cycle sustained while the result side does not stall; each
// result passes through the input register, error stage, product stage and
// result register. Error state updates in the error stage, so items see
// each other's state back to back. Synchronous reset clears the pipeline and
// the state and loads the registers with their reset values. Each stage holds
// only while its successor is full and holding; bubbles are squeezed out.
// ----------------------------------------------------------------------------
module pid_integral_separation_unit import pis_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [15:0] req_measurement,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [19:0]        rsp_drive,
   output logic               rsp_integral_active,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [7:0]         csr_index,
   input  logic [31:0]        csr_wdata
);

   // Configuration registers
   logic signed [15:0] setpoint_ff;
   logic [31:0]        gain_p_ff;
   logic [31:0]        gain_i_ff;
   logic [31:0]        gain_d_ff;
   logic signed [31:0] sum_high_ff;
   logic signed [31:0] sum_low_ff;
   logic [16:0]        sep_limit_ff;
   logic [19:0]        out_max_ff;

   // Controller state
   logic signed [31:0] error_sum_ff, error_sum_in;
   logic signed [16:0] last_err_ff, last_err_in;
   logic signed [16:0] prev_err_ff, prev_err_in;

   // Pipeline
   logic               v0_ff, v1_ff, v2_ff, v3_ff;
   logic               rdy0, rdy1, rdy2, rdy3;
   logic               adv1;
   logic signed [15:0] meas_ff;
   pis_err_type        err_ff, err_in;
   pis_ctrl_type       ctrl;

   // Error stage signals
   logic signed [16:0] err;
   logic [16:0]        mag;
   logic signed [16:0] last_eff;
   logic               active;
   logic               add;
   logic signed [32:0] sum_wide;

   assign csr_ready = 1'b1;

   // Write configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         setpoint_ff  <= SETPOINT_RST;
         gain_p_ff    <= GAIN_P_RST;
         gain_i_ff    <= GAIN_I_RST;
         gain_d_ff    <= GAIN_D_RST;
         sum_high_ff  <= SUM_HIGH_RST;
         sum_low_ff   <= SUM_LOW_RST;
         sep_limit_ff <= SEP_LIMIT_RST;
         out_max_ff   <= OUT_MAX_RST;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_SETPOINT:  setpoint_ff  <= csr_wdata[15:0];
            REG_GAIN_P:    gain_p_ff    <= csr_wdata;
            REG_GAIN_I:    gain_i_ff    <= csr_wdata;
            REG_GAIN_D:    gain_d_ff    <= csr_wdata;
            REG_SUM_HIGH:  sum_high_ff  <= csr_wdata;
            REG_SUM_LOW:   sum_low_ff   <= csr_wdata;
            REG_SEP_LIMIT: sep_limit_ff <= csr_wdata[16:0];
            REG_OUT_MAX:   out_max_ff   <= csr_wdata[19:0];
            default: ;
         endcase
      end
   end

   // Ready chain from the result side back to the input
   always_comb begin
      rdy3      = !v3_ff || !rsp_stall;
      rdy2      = !v2_ff || rdy3;
      rdy1      = !v1_ff || rdy2;
      rdy0      = !v0_ff || rdy1;
      adv1      = v0_ff && rdy1;
      ctrl.adv_mul = v1_ff && rdy2;
      ctrl.adv_out = v2_ff && rdy3;
   end

   assign req_stall = !rdy0;
   assign rsp_valid = v3_ff;

   // Advance valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         if (rdy0) v0_ff <= req_valid;
         if (rdy1) v1_ff <= v0_ff;
         if (rdy2) v2_ff <= v1_ff;
         if (rdy3) v3_ff <= v2_ff;
      end
   end

   // Capture the sample
   always_ff @(posedge clock) begin
      if (req_valid && rdy0) begin
         meas_ff <= req_measurement;
      end
   end

   // Error, separation, conditional integration and lagged difference
   always_comb begin
      err      = {meas_ff[15], meas_ff} - {setpoint_ff[15], setpoint_ff};
      mag      = err[16] ? 17'(-err) : err;
      last_eff = (last_err_ff == 17'sd0) ? err : last_err_ff;
      active   = mag <= sep_limit_ff;
      if (!active) begin
         add = 1'b0;
      end else if (error_sum_ff >= sum_high_ff) begin
         add = err[16];
      end else if (error_sum_ff <= sum_low_ff) begin
         add = !err[16] && (err != 17'sd0);
      end else begin
         add = 1'b1;
      end
      sum_wide = {error_sum_ff[31], error_sum_ff} + 33'(err);
      if (!add) begin
         error_sum_in = error_sum_ff;
      end else if (sum_wide[32] != sum_wide[31]) begin
         error_sum_in = sum_wide[32] ? SUM_MIN : SUM_MAX;
      end else begin
         error_sum_in = sum_wide[31:0];
      end
      prev_err_in   = last_eff;
      last_err_in   = err;
      err_in.err    = err;
      err_in.diff   = {last_eff[16], last_eff} - {prev_err_ff[16], prev_err_ff};
      err_in.sum    = active ? error_sum_in : 32'sd0;
      err_in.active = active;
      err_in.big    = mag >= BIG_ERROR;
   end

   // Update state as each item leaves the input register
   always_ff @(posedge clock) begin
      if (reset) begin
         error_sum_ff <= 32'sd0;
         last_err_ff  <= 17'sd0;
         prev_err_ff  <= 17'sd0;
      end else if (adv1) begin
         error_sum_ff <= error_sum_in;
         last_err_ff  <= last_err_in;
         prev_err_ff  <= prev_err_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv1) begin
         err_ff <= err_in;
      end
   end

   pis_drive_path u_drive_path (
      .clock           (clock),
      .ctrl            (ctrl),
      .err_stage       (err_ff),
      .gain_p          (gain_p_ff),
      .gain_i          (gain_i_ff),
      .gain_d          (gain_d_ff),
      .out_max         (out_max_ff),
      .drive           (rsp_drive),
      .integral_active (rsp_integral_active)
   );

   // Drive stays at or above the floor unless pushed to a low out_max plus one
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_drive >= DRIVE_FLOOR || rsp_drive == out_max_ff + 20'd1))
      else $error("drive below floor");

   // Input stalls only when every stage is full and the output holds
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (v0_ff && v1_ff && v2_ff && v3_ff && rsp_stall))
      else $error("input stalled with room in the pipeline");

   // Error sum holds for an item with the integral off
   assert property (@(posedge clock) disable iff (reset)
      (adv1 && !active) |=> $stable(error_sum_ff))
      else $error("error sum changed with integral off");

   // No result right after reset
   assert property (@(posedge clock)
      $fell(reset) |-> !rsp_valid)
      else $error("result valid after reset");

endmodule

>>> sim/pis_drive_monitor.sv
// ----------------------------------------------------------------------------
// pis_drive_monitor
// Watches the sample, result and register channels of the PID unit. It keeps
// its own copy of the registers and of the error state, works out the drive
// and integral flag for every sample transfer, and compares each result
// transfer against the oldest pending prediction.
// ----------------------------------------------------------------------------
module pis_drive_monitor import pis_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_stall,
   input  logic signed [15:0] req_measurement,
   input  logic               rsp_valid,
   input  logic               rsp_stall,
   input  logic [19:0]        rsp_drive,
   input  logic               rsp_integral_active,
   input  logic               csr_valid,
   input  logic               csr_ready,
   input  logic [7:0]         csr_index,
   input  logic [31:0]        csr_wdata,
   output int                 failures,
   output int                 outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam longint LONG_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
   localparam longint LONG_MIN = 64'sh8000_0000_0000_0000;

   typedef struct packed {
      logic [19:0] drive;
      logic        integral_active;
   } drive_result_type;

   // Register copies
   logic signed [15:0] setpoint_ff;
   logic [31:0]        gain_p_ff;
   logic [31:0]        gain_i_ff;
   logic [31:0]        gain_d_ff;
   logic signed [31:0] sum_high_ff;
   logic signed [31:0] sum_low_ff;
   logic [16:0]        sep_limit_ff;
   logic [19:0]        out_max_ff;

   // Controller state
   int error_sum;
   int last_err;
   int prev_err;

   drive_result_type pending_drives [$];

   // Advance the error state by one sample and form the drive
   function automatic void compute_drive(input logic signed [15:0] meas,
                                         output logic [19:0] drv,
                                         output logic act);
      int     err;
      int     mag;
      int     diff;
      logic   do_add;
      longint acc;
      longint kp, ki, kd;
      longint prod_p, prod_i, prod_d, total, level;
      longint sep_l, floor_l, max_l, out_l, big_l;
      sep_l   = sep_limit_ff;
      floor_l = DRIVE_FLOOR;
      max_l   = DRIVE_MAX;
      out_l   = out_max_ff;
      big_l   = BIG_ERROR;
      kp      = gain_p_ff;
      ki      = gain_i_ff;
      kd      = gain_d_ff;

      err = int'(meas) - int'(setpoint_ff);
      mag = (err < 0) ? -err : err;
      if (last_err == 0) last_err = err;

      // Integral separation, then conditional integration against the bounds
      act    = (mag <= sep_l);
      do_add = 1'b0;
      if (act) begin
         if (error_sum >= sum_high_ff) do_add = (err < 0);
         else if (error_sum <= sum_low_ff) do_add = (err > 0);
         else do_add = 1'b1;
      end
      if (do_add) begin
         acc = longint'(error_sum) + err;
         if (acc > SUM_MAX) acc = SUM_MAX;
         if (acc < SUM_MIN) acc = SUM_MIN;
         error_sum = int'(acc);
      end

      // Lagged derivative
      diff     = last_err - prev_err;
      prev_err = last_err;
      last_err = err;

      // Sum the three terms, saturating at the 64-bit range
      prod_p = kp * err;
      prod_d = kd * diff;
      prod_i = act ? ki * error_sum : 64'sd0;
      total  = prod_p + prod_d;
      if (prod_i > 0 && total > LONG_MAX - prod_i) total = LONG_MAX;
      else if (prod_i < 0 && total < LONG_MIN - prod_i) total = LONG_MIN;
      else total = total + prod_i;

      // Scale, floor, push past out_max on large error, clip to 20 bits
      level = total >>> 20;
      if (level <= floor_l) level = floor_l;
      if (level >= out_l && mag >= big_l) level = out_l + 1;
      if (level > max_l) level = max_l;
      if (level < 0) level = 0;
      drv = level[19:0];
   endfunction

   always @(posedge clock) begin
      drive_result_type want;
      drive_result_type got;
      if (reset) begin
         setpoint_ff  <= SETPOINT_RST;
         gain_p_ff    <= GAIN_P_RST;
         gain_i_ff    <= GAIN_I_RST;
         gain_d_ff    <= GAIN_D_RST;
         sum_high_ff  <= SUM_HIGH_RST;
         sum_low_ff   <= SUM_LOW_RST;
         sep_limit_ff <= SEP_LIMIT_RST;
         out_max_ff   <= OUT_MAX_RST;
         error_sum = 0;
         last_err  = 0;
         prev_err  = 0;
         pending_drives.delete();
      end else begin
         // Mirror register writes; unused indexes fall through
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_SETPOINT:  setpoint_ff  <= csr_wdata[15:0];
               REG_GAIN_P:    gain_p_ff    <= csr_wdata;
               REG_GAIN_I:    gain_i_ff    <= csr_wdata;
               REG_GAIN_D:    gain_d_ff    <= csr_wdata;
               REG_SUM_HIGH:  sum_high_ff  <= csr_wdata;
               REG_SUM_LOW:   sum_low_ff   <= csr_wdata;
               REG_SEP_LIMIT: sep_limit_ff <= csr_wdata[16:0];
               REG_OUT_MAX:   out_max_ff   <= csr_wdata[19:0];
               default: ;
            endcase
         end

         // Check a result transfer against the oldest prediction
         if (rsp_valid && !rsp_stall) begin
            got.drive           = rsp_drive;
            got.integral_active = rsp_integral_active;
            if (pending_drives.size() == 0) begin
               $error("unexpected result: drive %0d integral_active %0b",
                      got.drive, got.integral_active);
               failures++;
            end else begin
               want = pending_drives.pop_front();
               if (got.drive !== want.drive) begin
                  $error("drive: expected %0d, actual %0d", want.drive, got.drive);
                  failures++;
               end
               if (got.integral_active !== want.integral_active) begin
                  $error("integral_active: expected %0b, actual %0b",
                         want.integral_active, got.integral_active);
                  failures++;
               end
            end
         end

         // Predict on every sample transfer
         if (req_valid && !req_stall) begin
            compute_drive(req_measurement, want.drive, want.integral_active);
            pending_drives.push_back(want);
         end
      end
      outstanding <= pending_drives.size();
   end

endmodule

>>> sim/pid_integral_separation_unit_test.sv
// ----------------------------------------------------------------------------
// pid_integral_separation_unit_test
// Drives samples and register writes into the PID unit with random gaps and
// result stalls, lets the monitor check every result, and gives the verdict.
// Covers corner samples, extreme and crossed register settings, random
// settings with drifting samples, a long result hold, and full-scale errors
// that push the error sum and the drive hard in both directions.
// ----------------------------------------------------------------------------
module pid_integral_separation_unit_test;
   timeunit 1ns;
   timeprecision 1ps;
   import pis_pkg::*;

   localparam int RANDOM_PHASES = 9;
   localparam int PHASE_ITEMS   = 95;
   localparam int HOLD_CYCLES   = 80;
   localparam int CLIMB_ITEMS   = 20;
   localparam int FALL_ITEMS    = 40;

   logic               clock           = 1'b0;
   logic               reset           = 1'b1;
   logic               req_valid       = 1'b0;
   logic signed [15:0] req_measurement = '0;
   logic               rsp_stall       = 1'b0;
   logic               csr_valid       = 1'b0;
   logic [7:0]         csr_index       = '0;
   logic [31:0]        csr_wdata       = '0;
   logic               req_stall;
   logic               rsp_valid;
   logic [19:0]        rsp_drive;
   logic               rsp_integral_active;
   logic               csr_ready;

   int failures;
   int outstanding;
   bit send_idle = 1'b0;
   bit recv_idle = 1'b0;
   bit long_hold = 1'b0;
   int setpoint_now = 0;
   int sep_now = 320;
   int bias = 0;

   logic signed [15:0] corner_samples [14] = '{
      16'sd0, 16'sd0, 16'sd16, 16'sd79, 16'sd80, -16'sd80, 16'sd320,
      16'sd321, -16'sd321, 16'sd5000, 16'sh7FFF, 16'sh8000, 16'sh5555, 16'shAAAA
   };

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   pid_integral_separation_unit u_dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_measurement     (req_measurement),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_drive           (rsp_drive),
      .rsp_integral_active (rsp_integral_active),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata)
   );

   pis_drive_monitor u_monitor (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_measurement     (req_measurement),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_drive           (rsp_drive),
      .rsp_integral_active (rsp_integral_active),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata),
      .failures            (failures),
      .outstanding         (outstanding)
   );

   // Offer one sample after an optional gap; hold it until the transfer
   task automatic send_sample(input logic signed [15:0] meas);
      int gap;
      gap = send_idle ? $urandom_range(0, 3) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_measurement <= meas;
      do @(posedge clock); while (req_stall);
   endtask

   // Stop offering and wait until every predicted result has come back
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   // One register write; valid stays high for a following write
   task automatic write_register(input logic [7:0] idx, input logic [31:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
   endtask

   // Write every register plus one unused index, then release the port
   task automatic write_all(input logic [31:0] sp, input logic [31:0] gp,
                            input logic [31:0] gi, input logic [31:0] gd,
                            input logic [31:0] hi, input logic [31:0] lo,
                            input logic [31:0] sep, input logic [31:0] omax,
                            input logic [7:0] spare_index);
      write_register(REG_SETPOINT, sp);
      write_register(REG_GAIN_P, gp);
      write_register(REG_GAIN_I, gi);
      write_register(REG_GAIN_D, gd);
      write_register(REG_SUM_HIGH, hi);
      write_register(REG_SUM_LOW, lo);
      write_register(REG_SEP_LIMIT, sep);
      write_register(REG_OUT_MAX, omax);
      write_register(spare_index, $urandom);
      csr_valid    <= 1'b0;
      setpoint_now = int'($signed(sp[15:0]));
      sep_now      = int'(sep[16:0]);
   endtask

   // Draw a register setting: mostly workable values, sometimes raw bits
   task automatic random_config();
      logic [31:0] sp, gp, gi, gd, hi, lo, sep, omax;
      sp   = ($urandom_range(0, 3) == 0) ? $urandom :
             32'(int'($urandom_range(0, 1600)) - 800);
      gp   = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 32'h0200_0000);
      gi   = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 32'h0010_0000);
      gd   = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 32'h0010_0000);
      hi   = ($urandom_range(0, 5) == 0) ? $urandom :
             32'(int'($urandom_range(0, 40000)) - 10000);
      lo   = ($urandom_range(0, 5) == 0) ? $urandom :
             32'(10000 - int'($urandom_range(0, 40000)));
      sep  = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 1000);
      omax = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(8000, 40000);
      write_all(sp, gp, gi, gd, hi, lo, sep, omax, 8'($urandom_range(8, 255)));
   endtask

   // Samples drift around the setpoint so the sum walks into its bounds
   function automatic logic signed [15:0] next_sample();
      int pick;
      int span;
      int v;
      pick = $urandom_range(0, 9);
      span = (sep_now < 400) ? sep_now + 20 : 400;
      case (pick)
         0: return 16'($urandom);
         1: v = setpoint_now;
         2, 3, 4, 5: v = setpoint_now + bias + int'($urandom_range(0, 2 * span)) - span;
         default: v = setpoint_now + int'($urandom_range(0, 6000)) - 3000;
      endcase
      if (v > 32767) v = 32767;
      if (v < -32768) v = -32768;
      return v[15:0];
   endfunction

   // Result side: random stalls per result, one long hold on request
   initial begin
      int hold;
      forever begin
         if (long_hold) begin
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            long_hold = 1'b0;
         end else if (recv_idle) begin
            hold = $urandom_range(0, 3);
            if (hold > 0) begin
               rsp_stall <= 1'b1;
               repeat (hold) @(posedge clock);
            end
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   initial begin
      #20ms;
      $display("** pid_integral_separation_unit: FAILED **");
      $finish;
   end

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Corner samples under the reset setting
      send_idle = 1'b1;
      recv_idle = 1'b1;
      foreach (corner_samples[i]) send_sample(corner_samples[i]);
      drain();

      // Full gains, widest limits, crossed bounds, out_max at its top code
      write_all(32'hFFFF_8000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                SUM_MIN, SUM_MAX, 32'h0001_FFFF, 32'h000F_FFFF, 8'hFF);
      send_sample(16'sh7FFF);
      send_sample(16'sh7FFF);
      send_sample(16'sh8000);
      send_sample(16'sd0);
      drain();

      // Zero gains, zero separation limit, out_max at the drive floor, equal bounds
      write_all(32'h0000_7FFF, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0,
                32'd8000, 8'd8);
      send_sample(16'sh8000);
      send_sample(16'sh7FFF);
      send_sample(16'sd100);
      drain();

      // Random settings with drifting samples
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         random_config();
         send_idle = ($urandom_range(0, 3) != 0);
         recv_idle = ($urandom_range(0, 3) != 0);
         bias      = int'($urandom_range(0, 160)) - 80;
         if (phase == 2) begin
            send_idle = 1'b0;
            long_hold = 1'b1;
         end
         repeat (PHASE_ITEMS) send_sample(next_sample());
         drain();
      end

      // Climb the sum at full-scale error, then fall the other way
      send_idle = 1'b0;
      recv_idle = 1'b0;
      write_all(32'hFFFF_8000, 32'h0010_0000, 32'hFFFF_FFFF, 32'd0,
                SUM_MAX, SUM_MIN, 32'h0001_FFFF, 32'h000F_FFFF, 8'd200);
      repeat (CLIMB_ITEMS) send_sample(16'sh7FFF);
      drain();
      write_register(REG_SETPOINT, 32'h0000_7FFF);
      csr_valid <= 1'b0;
      repeat (FALL_ITEMS) send_sample(16'sh8000);
      drain();

      repeat (10) @(posedge clock);
      if (failures == 0) begin
         $display("** pid_integral_separation_unit: PASSED **");
      end else begin
         $display("** pid_integral_separation_unit: FAILED **");
      end
      $finish;
   end

endmodule

>>> filelist.f
sv/pis_pkg.sv
sv/pis_drive_path.sv
sv/pid_integral_separation_unit.sv
sim/pis_drive_monitor.sv
sim/pid_integral_separation_unit_test.sv
